FILE: design/tsg_pkg.sv
// Shared types and constants for the three-voice tone sample generator.
package tsg_pkg;

    // Configuration register indexes
    localparam logic CFG_NOTE_LENGTH = 1'b0;
    localparam logic CFG_AMPLITUDE   = 1'b1;

    // Envelope divider quotient and operand widths, and the triangle value width
    localparam int QUOT_W = 13;
    localparam int NUM_W  = 32;
    localparam int DEN_W  = 18;
    localparam int TRI_W  = 15;

    // Input beat: three voice frequencies in 0.01 Hz and the sample position
    typedef struct packed {
        logic [17:0] freq_square_a;
        logic [17:0] freq_square_b;
        logic [17:0] freq_tri;
        logic [15:0] sample_pos;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic signed [15:0] sample_wide;
        logic signed [7:0]  sample_byte;
    } t_out_item;

    // Side data carried alongside the envelope divider
    typedef struct packed {
        logic                    on_a;
        logic                    on_b;
        logic                    neg_a;
        logic                    neg_b;
        logic                    env_full;
        logic                    env_mid;
        logic signed [TRI_W-1:0] tri_val;
    } t_side;

endpackage

FILE: design/three_voice_tone_sample_generator_unit.sv
// Top level of the three-voice tone sample generator: phase, triangle and envelope pipeline.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_ready      | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready    | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One beat enters per cycle while the output is not stalled; a sample passes through 8 phase and
// triangle stages, 13 envelope divider stages and one output register.
// The envelope divider, one quotient bit per stage, sets the depth.
// A stalled output register freezes every stage at once; ready is high whenever the
// output register is empty or being drained. The config port is always ready.
// Reset clears every valid bit and loads note_length 1200 and amplitude 500.
module three_voice_tone_sample_generator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tsg_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tsg_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import tsg_pkg::*;

    // 800000 = 256 * 3125; divide by 3125 with a 2^-26 reciprocal and one fixup
    localparam logic [14:0] RECIP    = 15'd21474;
    localparam logic [11:0] DIV5P    = 12'd3125;
    localparam logic [19:0] HALF_DEN = 20'd400000;
    localparam logic [21:0] DEN1     = 22'd800000;
    localparam logic [21:0] DEN2     = 22'd1600000;
    localparam logic [21:0] DEN3     = 22'd2400000;
    localparam logic [21:0] DEN4     = 22'd3200000;

    // Configuration registers
    logic [15:0] r_note_len;
    logic [12:0] r_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_len <= 16'd1200;
            r_amp      <= 13'd500;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NOTE_LENGTH: r_note_len <= i_cfg_data;
                CFG_AMPLITUDE:   r_amp      <= i_cfg_data[12:0];
                default:         r_amp      <= r_amp;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Global advance: move everything unless the output register is held
    logic w_en;
    logic r_out_valid;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Stage 1: phase products, envelope region, distance to note end
    logic        r1_valid;
    logic [33:0] r1_p [3];
    logic        r1_on_a, r1_on_b, r1_full, r1_mid;
    logic [15:0] r1_d;
    logic [19:0] w1_s10, w1_l4;

    assign w1_s10 = {1'b0, i_in_data.sample_pos, 3'b000} + {3'b000, i_in_data.sample_pos, 1'b0};
    assign w1_l4  = {2'b00, r_note_len, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p[0] <= {16'b0, i_in_data.freq_square_a} * {18'b0, i_in_data.sample_pos};
            r1_p[1] <= {16'b0, i_in_data.freq_square_b} * {18'b0, i_in_data.sample_pos};
            r1_p[2] <= {16'b0, i_in_data.freq_tri} * {18'b0, i_in_data.sample_pos};
            r1_on_a <= i_in_data.freq_square_a != 18'd0;
            r1_on_b <= i_in_data.freq_square_b != 18'd0;
            r1_full <= w1_s10 <= w1_l4;
            r1_mid  <= i_in_data.sample_pos < r_note_len;
            r1_d    <= r_note_len - i_in_data.sample_pos;
        end
    end

    // Stage 2: quotient estimate by 3125, envelope numerator 5*A*(L-s)
    logic        r2_valid;
    logic [25:0] r2_x  [3];
    logic [7:0]  r2_lo [3];
    logic [14:0] r2_q  [3];
    logic [31:0] r2_num;
    logic        r2_on_a, r2_on_b, r2_full, r2_mid;
    logic [40:0] w2_m  [3];
    logic [15:0] w2_a5;

    assign w2_a5 = {3'b000, r_amp} + {1'b0, r_amp, 2'b00};

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            w2_m[v] = {15'b0, r1_p[v][33:8]} * {26'b0, RECIP};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int v = 0; v < 3; v++) begin
                r2_x[v]  <= r1_p[v][33:8];
                r2_lo[v] <= r1_p[v][7:0];
                r2_q[v]  <= w2_m[v][40:26];
            end
            r2_num  <= {16'b0, w2_a5} * {16'b0, r1_d};
            r2_on_a <= r1_on_a;
            r2_on_b <= r1_on_b;
            r2_full <= r1_full;
            r2_mid  <= r1_mid;
        end
    end

    // Stage 3: remainder of the estimate, below twice 3125
    logic        r3_valid;
    logic [12:0] r3_rem [3];
    logic [7:0]  r3_lo  [3];
    logic [31:0] r3_num;
    logic        r3_on_a, r3_on_b, r3_full, r3_mid;
    logic [26:0] w3_prod [3];
    logic [25:0] w3_diff [3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            w3_prod[v] = {12'b0, r2_q[v]} * {15'b0, DIV5P};
            w3_diff[v] = r2_x[v] - w3_prod[v][25:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int v = 0; v < 3; v++) begin
                r3_rem[v] <= w3_diff[v][12:0];
                r3_lo[v]  <= r2_lo[v];
            end
            r3_num  <= r2_num;
            r3_on_a <= r2_on_a;
            r3_on_b <= r2_on_b;
            r3_full <= r2_full;
            r3_mid  <= r2_mid;
        end
    end

    // Stage 4: phase fraction, square signs, triangle fold into one ramp
    logic        r4_valid;
    logic        r4_neg_a, r4_neg_b, r4_tneg;
    logic [19:0] r4_u;
    logic [31:0] r4_num;
    logic        r4_on_a, r4_on_b, r4_full, r4_mid;
    logic [19:0] w4_r [3];
    logic [11:0] w4_rf [3];
    logic [21:0] w4_t4, w4_u;
    logic        w4_tneg;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            w4_rf[v] = (r3_rem[v] >= {1'b0, DIV5P}) ? 12'(r3_rem[v] - {1'b0, DIV5P})
                                                     : r3_rem[v][11:0];
            w4_r[v]  = {w4_rf[v], r3_lo[v]};
        end
        w4_t4 = {w4_r[2], 2'b00};
        if (w4_t4 <= DEN1) begin
            w4_u    = w4_t4;
            w4_tneg = 1'b0;
        end else if (w4_t4 <= DEN2) begin
            w4_u    = DEN2 - w4_t4;
            w4_tneg = 1'b0;
        end else if (w4_t4 <= DEN3) begin
            w4_u    = w4_t4 - DEN2;
            w4_tneg = 1'b1;
        end else begin
            w4_u    = DEN4 - w4_t4;
            w4_tneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_neg_a <= w4_r[0] >= HALF_DEN;
            r4_neg_b <= w4_r[1] >= HALF_DEN;
            r4_tneg  <= w4_tneg;
            r4_u     <= w4_u[19:0];
            r4_num   <= r3_num;
            r4_on_a  <= r3_on_a;
            r4_on_b  <= r3_on_b;
            r4_full  <= r3_full;
            r4_mid   <= r3_mid;
        end
    end

    // Stage 5: triangle product A*u
    logic        r5_valid;
    logic [32:0] r5_au;
    logic        r5_neg_a, r5_neg_b, r5_tneg;
    logic [31:0] r5_num;
    logic        r5_on_a, r5_on_b, r5_full, r5_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_au    <= {20'b0, r_amp} * {13'b0, r4_u};
            r5_neg_a <= r4_neg_a;
            r5_neg_b <= r4_neg_b;
            r5_tneg  <= r4_tneg;
            r5_num   <= r4_num;
            r5_on_a  <= r4_on_a;
            r5_on_b  <= r4_on_b;
            r5_full  <= r4_full;
            r5_mid   <= r4_mid;
        end
    end

    // Stage 6: triangle quotient estimate by 3125 after the shift by 256
    logic        r6_valid;
    logic [24:0] r6_y;
    logic [12:0] r6_q;
    logic        r6_neg_a, r6_neg_b, r6_tneg;
    logic [31:0] r6_num;
    logic        r6_on_a, r6_on_b, r6_full, r6_mid;
    logic [39:0] w6_m;

    assign w6_m = {15'b0, r5_au[32:8]} * {25'b0, RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_y     <= r5_au[32:8];
            r6_q     <= w6_m[38:26];
            r6_neg_a <= r5_neg_a;
            r6_neg_b <= r5_neg_b;
            r6_tneg  <= r5_tneg;
            r6_num   <= r5_num;
            r6_on_a  <= r5_on_a;
            r6_on_b  <= r5_on_b;
            r6_full  <= r5_full;
            r6_mid   <= r5_mid;
        end
    end

    // Stage 7: triangle remainder
    logic        r7_valid;
    logic [12:0] r7_q, r7_rem;
    logic        r7_neg_a, r7_neg_b, r7_tneg;
    logic [31:0] r7_num;
    logic        r7_on_a, r7_on_b, r7_full, r7_mid;
    logic [24:0] w7_prod, w7_diff;

    assign w7_prod = {12'b0, r6_q} * {13'b0, DIV5P};
    assign w7_diff = r6_y - w7_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_q     <= r6_q;
            r7_rem   <= w7_diff[12:0];
            r7_neg_a <= r6_neg_a;
            r7_neg_b <= r6_neg_b;
            r7_tneg  <= r6_tneg;
            r7_num   <= r6_num;
            r7_on_a  <= r6_on_a;
            r7_on_b  <= r6_on_b;
            r7_full  <= r6_full;
            r7_mid   <= r6_mid;
        end
    end

    // Stage 8: correct the triangle magnitude, apply its sign, pack side data
    logic        r8_valid;
    t_side       r8_side;
    logic [31:0] r8_num;
    logic [12:0] w8_mag;
    logic [TRI_W-1:0] w8_tri;

    assign w8_mag = r7_q + {12'b0, r7_rem >= {1'b0, DIV5P}};
    assign w8_tri = r7_tneg ? TRI_W'(0) - {2'b00, w8_mag} : {2'b00, w8_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (w_en) begin
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_side.on_a     <= r7_on_a;
            r8_side.on_b     <= r7_on_b;
            r8_side.neg_a    <= r7_neg_a;
            r8_side.neg_b    <= r7_neg_b;
            r8_side.env_full <= r7_full;
            r8_side.env_mid  <= r7_mid;
            r8_side.tri_val  <= w8_tri;
            r8_num           <= r7_num;
        end
    end

    // Envelope divider: 5*A*(L-s) / (3*L)
    logic [DEN_W-1:0]  w_den3;
    logic              w_div_valid;
    logic [QUOT_W-1:0] w_div_quot;
    t_side             w_div_side;

    assign w_den3 = {2'b00, r_note_len} + {1'b0, r_note_len, 1'b0};

    tsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_valid),
        .i_num   (r8_num),
        .i_den   (w_den3),
        .i_side  (r8_side),
        .o_valid (w_div_valid),
        .o_quot  (w_div_quot),
        .o_side  (w_div_side)
    );

    // Output stage: envelope select, square signs, three-voice sum
    t_out_item   r_out;
    logic [12:0] w_env;
    logic [15:0] w_sq_a, w_sq_b, w_tri16, w_sum;

    always_comb begin
        if (w_div_side.env_full) begin
            w_env = r_amp;
        end else if (w_div_side.env_mid) begin
            w_env = w_div_quot;
        end else begin
            w_env = 13'd0;
        end
        w_sq_a = !w_div_side.on_a ? 16'd0 :
                 w_div_side.neg_a ? 16'd0 - {3'b000, w_env} : {3'b000, w_env};
        w_sq_b = !w_div_side.on_b ? 16'd0 :
                 w_div_side.neg_b ? 16'd0 - {3'b000, w_env} : {3'b000, w_env};
        w_tri16 = {w_div_side.tri_val[TRI_W-1], w_div_side.tri_val};
        w_sum   = w_sq_a + w_sq_b + w_tri16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.sample_wide <= w_sum;
            r_out.sample_byte <= w_sum[15:8];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/tsg_div.sv
// Pipelined restoring divider for the envelope, one quotient bit per stage.
module tsg_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [tsg_pkg::NUM_W-1:0]  i_num,
    input  logic [tsg_pkg::DEN_W-1:0]  i_den,
    input  tsg_pkg::t_side           i_side,
    output logic                     o_valid,
    output logic [tsg_pkg::QUOT_W-1:0] o_quot,
    output tsg_pkg::t_side           o_side
);
    import tsg_pkg::*;

    logic              r_valid [QUOT_W];
    logic [NUM_W-1:0]  r_rem   [QUOT_W];
    logic [QUOT_W-1:0] r_quot  [QUOT_W];
    t_side             r_side  [QUOT_W];

    logic              s_valid [QUOT_W+1];
    logic [NUM_W-1:0]  s_rem   [QUOT_W+1];
    logic [QUOT_W-1:0] s_quot  [QUOT_W+1];
    t_side             s_side  [QUOT_W+1];

    // Feed stage zero from the ports
    assign s_valid[0] = i_valid;
    assign s_rem[0]   = i_num;
    assign s_quot[0]  = '0;
    assign s_side[0]  = i_side;

    genvar j;
    generate
        for (j = 0; j < QUOT_W; j++) begin : g_stage
            localparam int BIT = QUOT_W - 1 - j;
            logic [NUM_W-1:0] w_trial;
            logic             w_ge;

            // Compare against the divisor shifted to this quotient bit
            assign w_trial = {{(NUM_W-DEN_W){1'b0}}, i_den} << BIT;
            assign w_ge    = s_rem[j] >= w_trial;

            // Advance the valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else if (i_en) begin
                    r_valid[j] <= s_valid[j];
                end
            end

            // Subtract when it fits and shift in the quotient bit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= w_ge ? s_rem[j] - w_trial : s_rem[j];
                    r_quot[j] <= {s_quot[j][QUOT_W-2:0], w_ge};
                    r_side[j] <= s_side[j];
                end
            end

            assign s_valid[j+1] = r_valid[j];
            assign s_rem[j+1]   = r_rem[j];
            assign s_quot[j+1]  = r_quot[j];
            assign s_side[j+1]  = r_side[j];
        end
    endgenerate

    assign o_valid = s_valid[QUOT_W];
    assign o_quot  = s_quot[QUOT_W];
    assign o_side  = s_side[QUOT_W];

endmodule

FILE: tb/tb_three_voice_tone_sample_generator_unit.sv
// Self-checking testbench for the three-voice tone sample generator.
module tb_three_voice_tone_sample_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tsg_pkg::*;

    // Phase denominators in units of 0.01 Hz times samples at 8 kHz
    localparam longint unsigned FULL_PHASE = 64'd800000;
    localparam longint unsigned HALF_PHASE = 64'd400000;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_BEATS  = 100;
    localparam int NUM_PHASES   = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_DIRECTED = 23;

    // One directed row: register setting, input beat, and an optional hand-typed result
    typedef struct packed {
        logic [15:0] len;
        logic [12:0] amp;
        t_in_item    beat;
        logic        typed;
        t_out_item   want;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // silent voices
        '{16'd1200, 13'd500, '{18'd0, 18'd0, 18'd0, 16'd0}, 1'b1, '{16'sd0, 8'sd0}},
        // both squares at the start of a note, positive half
        '{16'd1200, 13'd500, '{18'd1, 18'd1, 18'd0, 16'd0}, 1'b1, '{16'sd1000, 8'sd3}},
        // triangle at peak, zero crossing and trough
        '{16'd1200, 13'd500, '{18'd0, 18'd0, 18'd200000, 16'd1}, 1'b1, '{16'sd500, 8'sd1}},
        '{16'd1200, 13'd500, '{18'd0, 18'd0, 18'd200000, 16'd2}, 1'b1, '{16'sd0, 8'sd0}},
        '{16'd1200, 13'd500, '{18'd0, 18'd0, 18'd200000, 16'd3}, 1'b1,
          '{-16'sd500, -8'sd2}},
        // square in its negative half
        '{16'd1200, 13'd500, '{18'd200000, 18'd0, 18'd0, 16'd2}, 1'b1,
          '{-16'sd500, -8'sd2}},
        // triangle just past the three-quarter point and just short of the first quarter point
        '{16'd1200, 13'd500, '{18'd0, 18'd0, 18'd200001, 16'd3}, 1'b0, '0},
        '{16'd1200, 13'd500, '{18'd0, 18'd0, 18'd199999, 16'd1}, 1'b0, '0},
        // all fields at their maximum, past the note end
        '{16'd1200, 13'd500, '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 16'hFFFF}, 1'b0, '0},
        // end of the envelope hold and start of the decay
        '{16'd1200, 13'd500, '{18'd1000, 18'd5000, 18'd3000, 16'd480}, 1'b0, '0},
        '{16'd1200, 13'd500, '{18'd1000, 18'd5000, 18'd3000, 16'd481}, 1'b0, '0},
        // last sample of the note and the first past it
        '{16'd1200, 13'd500, '{18'd2200, 18'd3300, 18'd4400, 16'd1199}, 1'b0, '0},
        '{16'd1200, 13'd500, '{18'd2200, 18'd3300, 18'd4400, 16'd1200}, 1'b0, '0},
        // alternating bit patterns
        '{16'd1200, 13'd500, '{18'h2AAAA, 18'h15555, 18'h3FFFF, 16'h5555}, 1'b0, '0},
        '{16'd1200, 13'd500, '{18'h15555, 18'h2AAAA, 18'h20000, 16'hAAAA}, 1'b0, '0},
        // full amplitude, largest positive and negative sums
        '{16'd65535, 13'd8191, '{18'd200000, 18'd200000, 18'd200000, 16'd1}, 1'b1,
          '{16'sd24573, 8'sd95}},
        '{16'd65535, 13'd8191, '{18'd200000, 18'd200000, 18'd200000, 16'd3}, 1'b1,
          '{-16'sd24573, -8'sd96}},
        '{16'd65535, 13'd8191, '{18'h3FFFF, 18'd1, 18'd131071, 16'd40000}, 1'b0, '0},
        // zero note length: only the first sample keeps the squares
        '{16'd0, 13'd8191, '{18'd1, 18'd1, 18'd0, 16'd0}, 1'b0, '0},
        '{16'd0, 13'd8191, '{18'h3FFFF, 18'h3FFFF, 18'd0, 16'd5}, 1'b1, '{16'sd0, 8'sd0}},
        '{16'd0, 13'd8191, '{18'd7, 18'd9, 18'd123456, 16'd777}, 1'b0, '0},
        // zero amplitude
        '{16'd1, 13'd0, '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 16'd1234}, 1'b1, '{16'sd0, 8'sd0}},
        // shortest note
        '{16'd1, 13'd8191, '{18'd100000, 18'd0, 18'd0, 16'd1}, 1'b1, '{16'sd0, 8'sd0}}
    };

    // Register settings for the random phases; the last one is drawn at random
    localparam logic [15:0] PHASE_LEN [NUM_PHASES] =
        '{16'd1200, 16'd1, 16'd65535, 16'd65535, 16'd0, 16'd300, 16'd4000, 16'd50};
    localparam logic [12:0] PHASE_AMP [NUM_PHASES] =
        '{13'd500, 13'd8191, 13'd0, 13'd8191, 13'd4095, 13'd1, 13'd2500, 13'd7000};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_index = CFG_NOTE_LENGTH;
    logic [15:0] i_cfg_data = '0;

    // Register copies used by the predictor
    logic [15:0] note_len_now = 16'd1200;
    logic [12:0] amp_now      = 13'd500;

    t_out_item pending_sample = '0;
    t_out_item expected_samples [$];

    bit quiet = 1'b0;
    int err_count     = 0;
    int cycle_count   = 0;
    int beats_sent    = 0;
    int samples_seen  = 0;
    int settings_used = 1;

    three_voice_tone_sample_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Square voice: sign from the half-period parity, magnitude from the envelope
    function automatic int square_level(input longint unsigned f, input longint unsigned s);
        longint unsigned len;
        longint unsigned amp;
        longint unsigned mag;
        len = note_len_now;
        amp = amp_now;
        if (f == 0) return 0;
        if (10 * s <= 4 * len) mag = amp;
        else if (s < len) mag = (5 * amp * (len - s)) / (3 * len);
        else mag = 0;
        if (((f * s) / HALF_PHASE) % 2 == 0) return int'(mag);
        return -int'(mag);
    endfunction

    // Triangle voice from the phase fraction, each segment truncated toward zero
    function automatic int triangle_level(input longint unsigned f, input longint unsigned s);
        longint unsigned amp;
        longint unsigned r;
        amp = amp_now;
        if (f == 0) return 0;
        r = (f * s) % FULL_PHASE;
        if (4 * r <= FULL_PHASE) return int'((4 * amp * r) / FULL_PHASE);
        if (4 * r <= 2 * FULL_PHASE)
            return int'((amp * (2 * FULL_PHASE - 4 * r)) / FULL_PHASE);
        if (4 * r <= 3 * FULL_PHASE)
            return -int'((amp * (4 * r - 2 * FULL_PHASE)) / FULL_PHASE);
        return -int'((4 * amp * (FULL_PHASE - r)) / FULL_PHASE);
    endfunction

    function automatic t_out_item predict_sample(input t_in_item b);
        int total;
        logic signed [15:0] wide;
        t_out_item r;
        total = square_level(b.freq_square_a, b.sample_pos)
              + square_level(b.freq_square_b, b.sample_pos)
              + triangle_level(b.freq_tri, b.sample_pos);
        wide = total[15:0];
        r.sample_wide = wide;
        r.sample_byte = 8'(wide >>> 8);
        return r;
    endfunction

    function automatic logic [17:0] rand_freq();
        case ($urandom_range(6))
            0:       return 18'd0;
            1, 2, 3: return 18'($urandom_range(120000, 2000));
            default: return 18'($urandom_range(18'h3FFFF));
        endcase
    endfunction

    // Aim the note start at the envelope corners a quarter of the time
    function automatic logic [15:0] rand_pos(input int len);
        int p;
        case ($urandom_range(3))
            0:       p = $urandom_range(16'hFFFF);
            3:       p = ($urandom_range(1) ? (4 * len) / 10 : len) + $urandom_range(4);
            default: p = $urandom_range(len + len / 2 + 2);
        endcase
        if (p > 65535) p = 65535;
        return 16'(p);
    endfunction

    // Drive one beat, idling at random before it, and hold it until accepted
    task automatic send_sample(input t_in_item b, input t_out_item want);
        while (!quiet && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        pending_sample = want;
        i_in_data  <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every pending sample has come out
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (expected_samples.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] len, input logic [12:0] amp);
        hold_until_drained();
        write_reg(CFG_NOTE_LENGTH, len);
        write_reg(CFG_AMPLITUDE, 16'(amp));
        i_cfg_valid <= 1'b0;
        note_len_now = len;
        amp_now      = amp;
        settings_used++;
    endtask

    // Stall the output side at random, except during the quiet phase
    always @(negedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= 37);
    end

    // Check each output beat against the oldest expectation, then log new input beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                samples_seen++;
                if (expected_samples.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("[%0t] unexpected sample wide=%0d byte=%0d", $realtime,
                                 o_out_data.sample_wide, o_out_data.sample_byte);
                    err_count++;
                end else begin
                    t_out_item exp_s;
                    exp_s = expected_samples.pop_front();
                    if (o_out_data.sample_wide !== exp_s.sample_wide ||
                        o_out_data.sample_byte !== exp_s.sample_byte) begin
                        if (err_count < MAX_REPORTS)
                            $display("[%0t] wide exp %0d got %0d, byte exp %0d got %0d",
                                     $realtime, exp_s.sample_wide, o_out_data.sample_wide,
                                     exp_s.sample_byte, o_out_data.sample_byte);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready)
                expected_samples.push_back(pending_sample);
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d samples outstanding", cycle_count,
                     expected_samples.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_directed_row row;
        t_in_item b;
        logic [17:0] fa, fb, ft;
        logic [15:0] s0;
        logic [15:0] len;
        logic [12:0] amp;
        int sent;
        int run;

        // Hold reset, then release it before the first beat
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows, reprogramming only when the setting changes
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.len != note_len_now || row.amp != amp_now)
                program_regs(row.len, row.amp);
            send_sample(row.beat, row.typed ? row.want : predict_sample(row.beat));
        end

        // Random notes: bursts of consecutive positions with fixed voices
        for (int p = 0; p < NUM_PHASES; p++) begin
            len = PHASE_LEN[p];
            amp = PHASE_AMP[p];
            if (p == NUM_PHASES - 1) begin
                len = 16'($urandom_range(16'hFFFF));
                amp = 13'($urandom_range(13'h1FFF));
            end
            program_regs(len, amp);
            quiet = (p == 3);
            sent = 0;
            while (sent < PHASE_BEATS) begin
                fa  = rand_freq();
                fb  = rand_freq();
                ft  = rand_freq();
                s0  = rand_pos(int'(len));
                run = $urandom_range(8, 1);
                for (int j = 0; j < run && sent < PHASE_BEATS; j++) begin
                    b = '{fa, fb, ft, 16'(s0 + j)};
                    send_sample(b, predict_sample(b));
                    sent++;
                    // Let the pipeline run dry mid-phase now and then
                    if ((p == 0 && sent == PHASE_BEATS / 2) || $urandom_range(199) == 0)
                        hold_until_drained();
                end
            end
        end
        quiet = 1'b0;

        // Drain and watch for stray output beats
        hold_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_samples.size() != 0) begin
            $display("%0d samples never came out", expected_samples.size());
            err_count++;
        end

        $display("Sent %0d beats (%0d directed) over %0d register settings; %0d samples checked",
                 beats_sent, NUM_DIRECTED, settings_used, samples_seen);
        $display("Failures: %0d", err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
